FILE: design/xfcu_pkg.sv
package xfcu_pkg;

  localparam int unsigned FlagW = 22;
  localparam int unsigned DataW = 64;

  // EFLAGS bit masks, bits 0 to 21
  localparam logic [FlagW-1:0] F_CF    = 22'h000001;
  localparam logic [FlagW-1:0] F_RSV1  = 22'h000002;
  localparam logic [FlagW-1:0] F_PF    = 22'h000004;
  localparam logic [FlagW-1:0] F_AF    = 22'h000010;
  localparam logic [FlagW-1:0] F_ZF    = 22'h000040;
  localparam logic [FlagW-1:0] F_SF    = 22'h000080;
  localparam logic [FlagW-1:0] F_TF    = 22'h000100;
  localparam logic [FlagW-1:0] F_IF    = 22'h000200;
  localparam logic [FlagW-1:0] F_DF    = 22'h000400;
  localparam logic [FlagW-1:0] F_OF    = 22'h000800;
  localparam logic [FlagW-1:0] F_IOPL  = 22'h003000;
  localparam logic [FlagW-1:0] F_NT    = 22'h004000;
  localparam logic [FlagW-1:0] F_RF    = 22'h010000;
  localparam logic [FlagW-1:0] F_AC    = 22'h040000;
  localparam logic [FlagW-1:0] F_VIF   = 22'h080000;
  localparam logic [FlagW-1:0] F_ID    = 22'h200000;
  localparam logic [FlagW-1:0] F_ARITH = F_OF | F_SF | F_ZF | F_AF | F_PF | F_CF;
  localparam logic [FlagW-1:0] F_SAHF  = F_SF | F_ZF | F_AF | F_PF | F_CF;
  localparam logic [FlagW-1:0] PUSH_IMAGE_MASK = 22'h3cffff;

  localparam int unsigned BitIf  = 9;
  localparam int unsigned BitVif = 19;
  localparam int unsigned BitVip = 20;

  localparam logic [FlagW-1:0] FLAGS_RESET = F_RSV1;

  localparam logic [1:0] MODE_REAL = 2'd0;
  localparam logic [1:0] MODE_V86  = 2'd2;
  localparam logic [1:0] CPL_USER  = 2'd3;
  localparam logic [1:0] IOPL_MAX  = 2'd3;

  localparam logic [1:0] CFG_VME   = 2'd0;
  localparam logic [1:0] CFG_PVI   = 2'd1;
  localparam logic [1:0] CFG_AC_ID = 2'd2;

  typedef enum logic [3:0] {
    CMD_SAHF    = 4'd0,
    CMD_LAHF    = 4'd1,
    CMD_CLC     = 4'd2,
    CMD_STC     = 4'd3,
    CMD_CLI     = 4'd4,
    CMD_STI     = 4'd5,
    CMD_CLD     = 4'd6,
    CMD_STD     = 4'd7,
    CMD_CMC     = 4'd8,
    CMD_PUSHF16 = 4'd9,
    CMD_PUSHF32 = 4'd10,
    CMD_PUSHF64 = 4'd11,
    CMD_POPF16  = 4'd12,
    CMD_POPF32  = 4'd13,
    CMD_POPF64  = 4'd14,
    CMD_SALC    = 4'd15
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PUSH = 2'd1,
    KIND_AH   = 2'd2,
    KIND_AL   = 2'd3
  } kind_e;

  typedef struct packed {
    logic vme;
    logic pvi;
    logic ac_id;
  } cfg_t;

  typedef struct packed {
    cmd_e        command;
    logic [1:0]  cur_privilege;
    logic [1:0]  cpu_mode;
    logic [63:0] popped_value;
    logic [7:0]  ah_value;
  } item_t;

  typedef struct packed {
    logic             fault;
    kind_e            data_kind;
    logic [DataW-1:0] data_value;
    logic [FlagW-1:0] flags_now;
    logic             irq_shadow;
  } result_t;

endpackage

FILE: design/xfcu_cfg.sv
module xfcu_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic             cfg_data_i,
  output xfcu_pkg::cfg_t   cfg_o
);

  xfcu_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        xfcu_pkg::CFG_VME:   cfg_d.vme   = cfg_data_i;
        xfcu_pkg::CFG_PVI:   cfg_d.pvi   = cfg_data_i;
        xfcu_pkg::CFG_AC_ID: cfg_d.ac_id = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vme   <= 1'b0;
      cfg_q.pvi   <= 1'b0;
      cfg_q.ac_id <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/xfcu_exec.sv
module xfcu_exec (
  input  xfcu_pkg::item_t                 item_i,
  input  xfcu_pkg::cfg_t                  cfg_i,
  input  logic [xfcu_pkg::FlagW-1:0]      flags_i,
  output xfcu_pkg::result_t               res_o
);

  logic                         prot, v86, pvi_user, vip;
  logic [1:0]                   iopl, cpl;
  logic [xfcu_pkg::FlagW-1:0]   wmask, wval, popped;
  logic                         flt, shadow;
  xfcu_pkg::kind_e              kind;
  logic [xfcu_pkg::DataW-1:0]   data;

  always_comb begin
    cpl      = item_i.cur_privilege;
    v86      = (item_i.cpu_mode == xfcu_pkg::MODE_V86);
    prot     = !v86 && (item_i.cpu_mode != xfcu_pkg::MODE_REAL);
    iopl     = flags_i[13:12];
    vip      = flags_i[xfcu_pkg::BitVip];
    pvi_user = cfg_i.pvi && (cpl == xfcu_pkg::CPL_USER);
    popped   = item_i.popped_value[xfcu_pkg::FlagW-1:0];
    wmask    = '0;
    wval     = '0;
    flt      = 1'b0;
    shadow   = 1'b0;
    kind     = xfcu_pkg::KIND_NONE;
    data     = '0;

    unique case (item_i.command)
      xfcu_pkg::CMD_SAHF: begin
        wmask = xfcu_pkg::F_SAHF;
        wval  = {14'd0, item_i.ah_value};
      end
      xfcu_pkg::CMD_LAHF: begin
        kind = xfcu_pkg::KIND_AH;
        data = {56'd0, flags_i[7:0]};
      end
      xfcu_pkg::CMD_CLC: wmask = xfcu_pkg::F_CF;
      xfcu_pkg::CMD_STC: begin
        wmask = xfcu_pkg::F_CF;
        wval  = xfcu_pkg::F_CF;
      end
      xfcu_pkg::CMD_CLI: begin
        wmask = xfcu_pkg::F_IF;
        if (prot) begin
          if (pvi_user && iopl < xfcu_pkg::IOPL_MAX) begin
            wmask = xfcu_pkg::F_VIF;
          end else if (!pvi_user && iopl < cpl) begin
            flt = 1'b1;
          end
        end else if (v86 && iopl != xfcu_pkg::IOPL_MAX) begin
          if (cfg_i.vme) wmask = xfcu_pkg::F_VIF;
          else           flt   = 1'b1;
        end
      end
      xfcu_pkg::CMD_STI: begin
        wmask  = xfcu_pkg::F_IF;
        wval   = xfcu_pkg::F_IF;
        shadow = !flags_i[xfcu_pkg::BitIf];
        // virtual path: set VIF only, never raise the shadow
        if (prot) begin
          if (pvi_user && iopl < xfcu_pkg::IOPL_MAX) begin
            wmask  = xfcu_pkg::F_VIF;
            wval   = xfcu_pkg::F_VIF;
            shadow = 1'b0;
            flt    = vip;
          end else if (cpl > iopl) begin
            flt = 1'b1;
          end
        end else if (v86 && iopl != xfcu_pkg::IOPL_MAX) begin
          wmask  = xfcu_pkg::F_VIF;
          wval   = xfcu_pkg::F_VIF;
          shadow = 1'b0;
          flt    = !(cfg_i.vme && !vip);
        end
      end
      xfcu_pkg::CMD_CLD: wmask = xfcu_pkg::F_DF;
      xfcu_pkg::CMD_STD: begin
        wmask = xfcu_pkg::F_DF;
        wval  = xfcu_pkg::F_DF;
      end
      xfcu_pkg::CMD_CMC: begin
        wmask = xfcu_pkg::F_CF;
        wval  = ~flags_i;
      end
      xfcu_pkg::CMD_PUSHF16: begin
        kind = xfcu_pkg::KIND_PUSH;
        data = {48'd0, flags_i[15:0]};
        if (v86 && iopl < xfcu_pkg::IOPL_MAX) begin
          // VME image: IOPL reads as 3, IF reflects VIF
          flt            = !cfg_i.vme;
          data[13:12]    = 2'b11;
          data[xfcu_pkg::BitIf] = flags_i[xfcu_pkg::BitVif];
        end
      end
      xfcu_pkg::CMD_PUSHF32: begin
        kind = xfcu_pkg::KIND_PUSH;
        data = {42'd0, flags_i & xfcu_pkg::PUSH_IMAGE_MASK};
        flt  = v86 && iopl < xfcu_pkg::IOPL_MAX;
      end
      xfcu_pkg::CMD_PUSHF64: begin
        kind = xfcu_pkg::KIND_PUSH;
        data = {42'd0, flags_i & xfcu_pkg::PUSH_IMAGE_MASK};
      end
      xfcu_pkg::CMD_POPF16: begin
        wmask = xfcu_pkg::F_ARITH | xfcu_pkg::F_TF | xfcu_pkg::F_DF | xfcu_pkg::F_NT;
        wval  = {6'd0, popped[15:0]};
        if (prot) begin
          if (cpl == 2'd0) wmask = wmask | xfcu_pkg::F_IOPL;
          if (cpl <= iopl) wmask = wmask | xfcu_pkg::F_IF;
        end else if (v86) begin
          if (iopl < xfcu_pkg::IOPL_MAX) begin
            flt = !cfg_i.vme || (popped[xfcu_pkg::BitIf] && vip) || popped[8];
            // VIF follows the popped IF; IF and IOPL hold
            wmask = wmask | xfcu_pkg::F_VIF;
            wval[xfcu_pkg::BitVif] = popped[xfcu_pkg::BitIf];
          end else begin
            wmask = wmask | xfcu_pkg::F_IF;
          end
        end else begin
          wmask = wmask | xfcu_pkg::F_IOPL | xfcu_pkg::F_IF;
        end
      end
      xfcu_pkg::CMD_POPF32: begin
        wmask = xfcu_pkg::F_ARITH | xfcu_pkg::F_TF | xfcu_pkg::F_DF
              | xfcu_pkg::F_NT | xfcu_pkg::F_RF;
        if (cfg_i.ac_id) wmask = wmask | xfcu_pkg::F_AC | xfcu_pkg::F_ID;
        wval = popped;
        if (prot) begin
          if (cpl == 2'd0) wmask = wmask | xfcu_pkg::F_IOPL;
          if (cpl <= iopl) wmask = wmask | xfcu_pkg::F_IF;
        end else if (v86) begin
          flt   = iopl < xfcu_pkg::IOPL_MAX;
          wmask = wmask | xfcu_pkg::F_IF;
        end else begin
          wmask = wmask | xfcu_pkg::F_IOPL | xfcu_pkg::F_IF;
        end
      end
      xfcu_pkg::CMD_POPF64: begin
        wmask = xfcu_pkg::F_ARITH | xfcu_pkg::F_TF | xfcu_pkg::F_DF | xfcu_pkg::F_NT
              | xfcu_pkg::F_RF | xfcu_pkg::F_AC | xfcu_pkg::F_ID;
        wval  = popped;
        if (cpl == 2'd0) wmask = wmask | xfcu_pkg::F_IOPL;
        if (cpl <= iopl) wmask = wmask | xfcu_pkg::F_IF;
      end
      xfcu_pkg::CMD_SALC: begin
        kind = xfcu_pkg::KIND_AL;
        data = {56'd0, {8{flags_i[0]}}};
      end
    endcase

    if (flt) begin
      res_o.fault      = 1'b1;
      res_o.data_kind  = xfcu_pkg::KIND_NONE;
      res_o.data_value = '0;
      res_o.flags_now  = flags_i;
      res_o.irq_shadow = 1'b0;
    end else begin
      res_o.fault      = 1'b0;
      res_o.data_kind  = kind;
      res_o.data_value = data;
      res_o.flags_now  = (flags_i & ~wmask) | (wval & wmask) | xfcu_pkg::F_RSV1;
      res_o.irq_shadow = shadow;
    end
  end

endmodule

FILE: design/x86_flag_control_unit.sv
// x86 flag control unit: holds EFLAGS bits 0 to 21 and executes one flag instruction
// (SAHF, LAHF, CLC/STC/CMC, CLI/STI, CLD/STD, PUSHF and POPF in three widths, SALC) per
// item, with the real, protected and virtual-8086 privilege rules including the VME and
// PVI virtual-interrupt paths. Each item passes through an input register and then a result
// register, and a new item is taken every cycle unless the output stalls; the flag
// register is updated as an item moves into the result register, so the next item sees
// the new flags with no bubble. A faulting item leaves the flags untouched and returns
// fault with no data. Write configuration only while no item is in flight.
module x86_flag_control_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic          cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [1:0] cur_privilege, [3:2] cpu_mode, [67:4] popped_value, [75:68] ah_value
  input  logic [79:0]   s_axis_tdata,
  // [3:0] command
  input  logic [3:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [0] fault, [64:1] data_value, [86:65] flags_now, [87] irq_shadow
  output logic [87:0]   m_axis_tdata,
  // [1:0] data_kind
  output logic [1:0]    m_axis_tuser
);

  xfcu_pkg::cfg_t                  cfg;
  xfcu_pkg::item_t                 item_q, item_d;
  xfcu_pkg::result_t               res_q, res_d;
  logic                            in_valid_q, out_valid_q, adv;
  logic [xfcu_pkg::FlagW-1:0]      eflags_q;

  xfcu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  xfcu_exec u_exec (
    .item_i  (item_q),
    .cfg_i   (cfg),
    .flags_i (eflags_q),
    .res_o   (res_d)
  );

  // advance the held item whenever the result slot is free or draining
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_comb begin
    item_d.command       = xfcu_pkg::cmd_e'(s_axis_tuser);
    item_d.cur_privilege = s_axis_tdata[1:0];
    item_d.cpu_mode      = s_axis_tdata[3:2];
    item_d.popped_value  = s_axis_tdata[67:4];
    item_d.ah_value      = s_axis_tdata[75:68];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      eflags_q    <= xfcu_pkg::FLAGS_RESET;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) begin
        out_valid_q <= 1'b1;
        eflags_q    <= res_d.flags_now;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) item_q <= item_d;
    if (adv) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.irq_shadow, res_q.flags_now, res_q.data_value, res_q.fault};
  assign m_axis_tuser  = res_q.data_kind;

  a_fault_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == xfcu_pkg::KIND_NONE
                                            && !m_axis_tdata[87]))
    else $error("faulting item carries data or shadow");

  a_fault_holds_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res_d.fault) |=> $stable(eflags_q))
    else $error("flags changed on a faulting item");

  a_rsv1_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eflags_q[1])
    else $error("reserved flag bit 1 cleared");

  a_shadow_if : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[87]) |-> m_axis_tdata[65 + xfcu_pkg::BitIf])
    else $error("interrupt shadow without IF set");

endmodule
